// File: hw/rtl/playfair_digraph_cipher_defines.svh
// ----------------------------------------------------------------------------
// Playfair digraph cipher assertion macros
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher package
// Grid geometry, letter codes, configuration indexes and shared types.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // Grid geometry and field widths.
    localparam int GridSize = 5;
    localparam int Cells    = GridSize * GridSize;
    localparam int CodeW    = 5;
    localparam int LetterW  = 7;
    localparam int CfgDataW = 60;
    localparam int GridW    = Cells * CodeW;

    typedef logic [CodeW-1:0]    code_t;
    typedef logic [GridSize-1:0] line_oh_t;

    // Letter codes with A as zero.
    localparam code_t CodeI = 5'd8;
    localparam code_t CodeJ = 5'd9;
    localparam code_t CodeQ = 5'd16;
    localparam code_t CodeX = 5'd23;
    localparam code_t CodeZ = 5'd25;

    // ASCII landmarks.
    localparam logic [7:0] AsciiUpA   = 8'h41;
    localparam logic [7:0] AsciiUpZ   = 8'h5A;
    localparam logic [7:0] AsciiLowA  = 8'h61;
    localparam logic [7:0] AsciiLowZ  = 8'h7A;
    localparam logic [7:0] CaseOffset = 8'h20;
    localparam logic [LetterW-1:0] LetterBase = 7'h41;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_GRID_A = 2'd1,
        CFG_GRID_B = 2'd2,
        CFG_GRID_C = 2'd3
    } cfg_index_t;

    // Configuration state seen by the cipher stage.
    typedef struct packed {
        logic             decrypt;
        logic [GridW-1:0] grid;
    } cfg_state_t;

    // One result to be ciphered: a digraph or the empty end marker.
    typedef struct packed {
        logic  marker;
        code_t first;
        code_t second;
        logic  last;
    } pair_entry_t;

    // Head of the pair queue offered to the cipher stage.
    typedef struct packed {
        logic        valid;
        pair_entry_t entry;
    } pair_slot_t;

    // Rotate a one-hot row or column position by one place, forward or back.
    function automatic line_oh_t rotate_oh(line_oh_t v, logic back);
        line_oh_t res;
        for (int i = 0; i < GridSize; i++) begin
            if (back) begin
                res[i] = v[(i + 1) % GridSize];
            end else begin
                res[i] = v[(i + GridSize - 1) % GridSize];
            end
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/pdc_regs.sv
// ----------------------------------------------------------------------------
// Playfair configuration registers
// Holds the cipher direction and the 25 packed grid cells.
// ----------------------------------------------------------------------------
module pdc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [pdc_pkg::CfgDataW-1:0]  cfg_data,
    output pdc_pkg::cfg_state_t           cfg_state
);

    logic                       decrypt_reg;
    logic [pdc_pkg::GridW-1:0]  grid_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register writes; the grid words land directly on their cell fields.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
            grid_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (pdc_pkg::cfg_index_t'(cfg_index))
                pdc_pkg::CFG_MODE:   decrypt_reg <= cfg_data[0];
                pdc_pkg::CFG_GRID_A: grid_reg[59:0] <= cfg_data;
                pdc_pkg::CFG_GRID_B: grid_reg[119:60] <= cfg_data;
                pdc_pkg::CFG_GRID_C: grid_reg[124:120] <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign cfg_state.decrypt = decrypt_reg;
    assign cfg_state.grid    = grid_reg;

endmodule

// File: hw/rtl/pdc_pairer.sv
// ----------------------------------------------------------------------------
// Playfair digraph pairer
// Folds bytes to letter codes, forms digraphs with one pending letter and
// queues up to two results per item for the cipher stage.
// ----------------------------------------------------------------------------
module pdc_pairer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_text_byte,
    input  logic                s_final_byte,
    output pdc_pkg::pair_slot_t head,
    input  logic                take
);

    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    pdc_pkg::code_t         pend_letter_reg;
    pdc_pkg::code_t         pend_letter_next;
    logic [1:0]             ent_valid_reg;
    logic [1:0]             ent_valid_next;
    pdc_pkg::pair_entry_t   ent0_reg;
    pdc_pkg::pair_entry_t   ent1_reg;
    pdc_pkg::pair_entry_t   ent0_next;
    pdc_pkg::pair_entry_t   ent1_next;
    logic [7:0]             folded;
    logic                   is_letter;
    pdc_pkg::code_t         code;
    pdc_pkg::pair_entry_t   pad;
    logic                   accept;

    // A new item enters when the queue is empty or its only entry leaves now.
    assign s_ready = !ent_valid_reg[0] || (take && !ent_valid_reg[1]);
    assign accept  = s_valid && s_ready;

    // Case folding, letter detection and the J to I merge.
    always_comb begin
        folded = s_text_byte;
        if (s_text_byte >= pdc_pkg::AsciiLowA && s_text_byte <= pdc_pkg::AsciiLowZ) begin
            folded = s_text_byte - pdc_pkg::CaseOffset;
        end
        is_letter = (folded >= pdc_pkg::AsciiUpA) && (folded <= pdc_pkg::AsciiUpZ);
        code = pdc_pkg::CodeW'(folded - pdc_pkg::AsciiUpA);
        if (code == pdc_pkg::CodeJ) begin
            code = pdc_pkg::CodeI;
        end
    end

    // Digraph forming: doubled letters take a filler, the final byte pads
    // a lone letter, flags the last digraph or emits the empty end marker.
    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        ent_valid_next   = 2'b00;
        ent0_next        = '0;
        ent1_next        = '0;
        pad              = '0;
        if (is_letter) begin
            if (pend_valid_reg) begin
                ent_valid_next[0] = 1'b1;
                ent0_next.first   = pend_letter_reg;
                if (code == pend_letter_reg) begin
                    ent0_next.second = (pend_letter_reg == pdc_pkg::CodeX) ?
                                       pdc_pkg::CodeQ : pdc_pkg::CodeX;
                end else begin
                    ent0_next.second = code;
                    pend_valid_next  = 1'b0;
                end
            end else begin
                pend_letter_next = code;
                pend_valid_next  = 1'b1;
            end
        end
        if (s_final_byte) begin
            pad.first  = pend_letter_next;
            pad.second = (pend_letter_next == pdc_pkg::CodeZ) ?
                         pdc_pkg::CodeX : pdc_pkg::CodeZ;
            pad.last   = 1'b1;
            if (pend_valid_next) begin
                if (ent_valid_next[0]) begin
                    ent1_next         = pad;
                    ent_valid_next[1] = 1'b1;
                end else begin
                    ent0_next         = pad;
                    ent_valid_next[0] = 1'b1;
                end
                pend_valid_next = 1'b0;
            end else if (ent_valid_next[0]) begin
                ent0_next.last = 1'b1;
            end else begin
                ent0_next.marker  = 1'b1;
                ent0_next.last    = 1'b1;
                ent_valid_next[0] = 1'b1;
            end
        end
    end

    // Pending letter and the two-entry result queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            ent_valid_reg   <= 2'b00;
        end else if (accept) begin
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            ent_valid_reg   <= ent_valid_next;
        end else if (take) begin
            ent_valid_reg   <= {1'b0, ent_valid_reg[1]};
        end
    end

    // Queue payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ent0_reg <= ent0_next;
            ent1_reg <= ent1_next;
        end else if (take) begin
            ent0_reg <= ent1_reg;
        end
    end

    assign head.valid = ent_valid_reg[0];
    assign head.entry = ent0_reg;

endmodule

// File: hw/rtl/pdc_cipher.sv
// ----------------------------------------------------------------------------
// Playfair cipher stage
// Locates both letters in the grid by parallel compare, applies the row,
// column or rectangle rule and registers the result item.
// ----------------------------------------------------------------------------
module pdc_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pdc_pkg::cfg_state_t                 cfg_state,
    input  pdc_pkg::pair_slot_t                 head,
    output logic                                take,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pdc_pkg::LetterW-1:0]         m_first_letter,
    output logic [pdc_pkg::LetterW-1:0]         m_second_letter,
    output logic                                m_pair_valid,
    output logic                                m_last_pair
);

    localparam int N = pdc_pkg::GridSize;

    logic [pdc_pkg::Cells-1:0]     match_a, match_b, hit_a, hit_b;
    logic [pdc_pkg::Cells-1:0]     cell_a, cell_b;
    pdc_pkg::line_oh_t             row_a, row_b, col_a, col_b;
    pdc_pkg::line_oh_t             row_a2, row_b2, col_a2, col_b2;
    pdc_pkg::code_t                code_a, code_b;
    logic [pdc_pkg::LetterW-1:0]   first_next, second_next;
    logic                          m_valid_reg;
    logic [pdc_pkg::LetterW-1:0]   first_reg, second_reg;
    logic                          pair_valid_reg, last_reg;

    assign take = head.valid && (!m_valid_reg || m_ready);

    // Letter lookup: lowest matching cell, cell zero when absent.
    always_comb begin
        for (int p = 0; p < pdc_pkg::Cells; p++) begin
            match_a[p] = cfg_state.grid[p*pdc_pkg::CodeW +: pdc_pkg::CodeW] == head.entry.first;
            match_b[p] = cfg_state.grid[p*pdc_pkg::CodeW +: pdc_pkg::CodeW] == head.entry.second;
        end
        hit_a = match_a & (~match_a + 1'b1);
        hit_b = match_b & (~match_b + 1'b1);
        if (match_a == '0) begin
            hit_a = pdc_pkg::Cells'(1);
        end
        if (match_b == '0) begin
            hit_b = pdc_pkg::Cells'(1);
        end
    end

    // One-hot row and column of each letter.
    always_comb begin
        row_a = '0;
        row_b = '0;
        col_a = '0;
        col_b = '0;
        for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
                row_a[r] = row_a[r] | hit_a[r*N + c];
                row_b[r] = row_b[r] | hit_b[r*N + c];
                col_a[c] = col_a[c] | hit_a[r*N + c];
                col_b[c] = col_b[c] | hit_b[r*N + c];
            end
        end
    end

    // Playfair rules: shift along a shared row or column, else swap columns.
    always_comb begin
        row_a2 = row_a;
        row_b2 = row_b;
        col_a2 = col_a;
        col_b2 = col_b;
        if (row_a == row_b) begin
            col_a2 = pdc_pkg::rotate_oh(col_a, cfg_state.decrypt);
            col_b2 = pdc_pkg::rotate_oh(col_b, cfg_state.decrypt);
        end else if (col_a == col_b) begin
            row_a2 = pdc_pkg::rotate_oh(row_a, cfg_state.decrypt);
            row_b2 = pdc_pkg::rotate_oh(row_b, cfg_state.decrypt);
        end else begin
            col_a2 = col_b;
            col_b2 = col_a;
        end
    end

    // Read the target cells through a one-hot select.
    always_comb begin
        code_a = '0;
        code_b = '0;
        for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
                cell_a[r*N + c] = row_a2[r] & col_a2[c];
                cell_b[r*N + c] = row_b2[r] & col_b2[c];
                if (cell_a[r*N + c]) begin
                    code_a = code_a |
                             cfg_state.grid[(r*N + c)*pdc_pkg::CodeW +: pdc_pkg::CodeW];
                end
                if (cell_b[r*N + c]) begin
                    code_b = code_b |
                             cfg_state.grid[(r*N + c)*pdc_pkg::CodeW +: pdc_pkg::CodeW];
                end
            end
        end
        if (head.entry.marker) begin
            first_next  = '0;
            second_next = '0;
        end else begin
            first_next  = pdc_pkg::LetterBase + {2'b00, code_a};
            second_next = pdc_pkg::LetterBase + {2'b00, code_b};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            first_reg      <= first_next;
            second_reg     <= second_next;
            pair_valid_reg <= !head.entry.marker;
            last_reg       <= head.entry.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_first_letter  = first_reg;
    assign m_second_letter = second_reg;
    assign m_pair_valid    = pair_valid_reg;
    assign m_last_pair     = last_reg;

endmodule

// File: hw/rtl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Streams raw text bytes into ciphered Playfair digraphs over a 5x5 grid.
// ----------------------------------------------------------------------------
// The block accepts one text byte per cycle while s_ready is high; results
// pass the pair queue and the output register. A byte yields no result, one
// result, or two (a doubled letter on the final byte); the cipher stage
// handles one digraph per cycle unless the output stalls, so a byte with two
// results holds the input. Software loads the grid as packed 5-bit letter
// codes and picks the direction; configuration writes are taken in any cycle
// but belong only between messages. A final byte with nothing left to send
// gives a single empty result with pair_valid low and last_pair high.
module playfair_digraph_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_text_byte,
    input  logic                                s_final_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pdc_pkg::LetterW-1:0]         m_first_letter,
    output logic [pdc_pkg::LetterW-1:0]         m_second_letter,
    output logic                                m_pair_valid,
    output logic                                m_last_pair,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [pdc_pkg::CfgDataW-1:0]        cfg_data
);

    pdc_pkg::cfg_state_t cfg_state;
    pdc_pkg::pair_slot_t head;
    logic                take;

    // Configuration registers.
    pdc_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_state (cfg_state)
    );

    // Byte folding and digraph forming.
    pdc_pairer u_pairer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_final_byte (s_final_byte),
        .head         (head),
        .take         (take)
    );

    // Grid lookup and result register.
    pdc_cipher u_cipher (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_state       (cfg_state),
        .head            (head),
        .take            (take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_letter  (m_first_letter),
        .m_second_letter (m_second_letter),
        .m_pair_valid    (m_pair_valid),
        .m_last_pair     (m_last_pair)
    );

endmodule

// File: hw/rtl/pdc_checker.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher port checker
// Watches the top-level ports for result framing and letter range.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_defines.svh"

module pdc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pdc_pkg::LetterW-1:0]   m_first_letter,
    input logic [pdc_pkg::LetterW-1:0]   m_second_letter,
    input logic                          m_pair_valid,
    input logic                          m_last_pair
);

    logic first_ok, second_ok;

    // Ciphered letters are 'A' plus a 5-bit cell code.
    assign first_ok  = (m_first_letter >= 7'h41) && (m_first_letter <= 7'h60);
    assign second_ok = (m_second_letter >= 7'h41) && (m_second_letter <= 7'h60);

    // The offered result item and all of its fields are unchanged from last cycle.
    sequence result_hold_s;
        m_valid && $stable(m_first_letter) && $stable(m_second_letter)
            && $stable(m_pair_valid) && $stable(m_last_pair);
    endsequence

    // A stalled result item stays offered and unchanged.
    `PDC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, result_hold_s, "stalled result item changed")

    // The empty end marker always closes a message and carries no letters.
    `PDC_ASSERT_SAME(a_marker_form, aclk, aresetn, m_valid && !m_pair_valid, m_last_pair && m_first_letter == 7'h00 && m_second_letter == 7'h00, "malformed end marker")

    // A digraph carries letters offset from 'A'.
    `PDC_ASSERT_SAME(a_letter_range, aclk, aresetn, m_valid && m_pair_valid, first_ok && second_ok, "digraph letter out of range")

endmodule

bind playfair_digraph_cipher pdc_checker u_pdc_checker (.*);
